/* rtl/core/weno5_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// weno5_pkg
// Shared types, widths and constants of the WENO5 face reconstruction block.
// ---------------------------------------------------------------------------
package weno5_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int FRACTION_BITS = 20;
  localparam int WEIGHT_BITS   = 24;

  // datapath widths
  localparam int DIFF_W  = SAMPLE_BITS + 4;   // second differences
  localparam int Q_W     = SAMPLE_BITS + 5;   // stencil numerators
  localparam int D_W     = 57;                // smoothness plus eps
  localparam int DN_BITS = 21;                // normalised indicator
  localparam int DVD_W   = 60;                // divider dividend / quotient
  localparam int DVS_W   = 42;                // divider divisor
  localparam int C_W     = 62;                // unnormalised weights
  localparam int CS_W    = 64;                // their sum
  localparam int CN_BITS = 32;                // normalised weight width
  localparam int CS2_W   = CN_BITS + 2;
  localparam int W_W     = WEIGHT_BITS + 1;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 56;
  localparam int Z_W     = 30;
  localparam int R_W     = 31;
  localparam int FILL_W  = 3;
  localparam int DIV_STEPS = DVD_W;
  localparam int DCNT_W  = $clog2(DIV_STEPS);

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(4);

  // eps scaled to 12 * 2^(2F) units, rounded
  localparam logic [63:0] EPS_WIDE =
    (64'd12 * (64'd1 << (2 * FRACTION_BITS)) + 64'd500000) / 64'd1000000;
  localparam logic [D_W-1:0] EPS_VAL = EPS_WIDE[D_W-1:0];

  localparam logic [DVD_W-1:0] INV_NUM = {1'b1, {(DVD_W-1){1'b0}}};   // 2^59

  // final scaling: floor((A + 3*2^24) / (6*2^24)) via a shift and a divide by 3
  localparam logic signed [ACC_W-1:0] RND_OFF = ACC_W'(64'd3 << WEIGHT_BITS);
  localparam int                      RND_SH  = WEIGHT_BITS + 1;
  localparam logic signed [ACC_W-1:0] Z_OFF   = ACC_W'(64'd3 << 27);
  localparam logic [MUL_W-1:0]        RECIP3  = 32'h2AAAAAAB;         // ceil(2^31/3)
  localparam int                      RECIP_SH = 31;
  localparam logic signed [R_W-1:0]   Q_OFF   = R_W'(64'd1 << 27);
  localparam logic signed [R_W-1:0]   RES_MAX = R_W'((64'd1 << (SAMPLE_BITS-1)) - 64'd1);
  localparam logic signed [R_W-1:0]   RES_MIN = -R_W'(64'd1 << (SAMPLE_BITS-1));

  // datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP   = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 5'd1;
  localparam logic [OP_W-1:0] OP_DINIT = 5'd2;
  localparam logic [OP_W-1:0] OP_SQA   = 5'd3;
  localparam logic [OP_W-1:0] OP_ACCA  = 5'd4;
  localparam logic [OP_W-1:0] OP_SQB   = 5'd5;
  localparam logic [OP_W-1:0] OP_ACCB  = 5'd6;
  localparam logic [OP_W-1:0] OP_MAXD  = 5'd7;
  localparam logic [OP_W-1:0] OP_NORM1 = 5'd8;
  localparam logic [OP_W-1:0] OP_SQD   = 5'd9;
  localparam logic [OP_W-1:0] OP_DIVQ  = 5'd10;
  localparam logic [OP_W-1:0] OP_STQ   = 5'd11;
  localparam logic [OP_W-1:0] OP_CINIT = 5'd12;
  localparam logic [OP_W-1:0] OP_NORM2 = 5'd13;
  localparam logic [OP_W-1:0] OP_CSUM  = 5'd14;
  localparam logic [OP_W-1:0] OP_DIVW  = 5'd15;
  localparam logic [OP_W-1:0] OP_STW   = 5'd16;
  localparam logic [OP_W-1:0] OP_ACLR  = 5'd17;
  localparam logic [OP_W-1:0] OP_MW    = 5'd18;
  localparam logic [OP_W-1:0] OP_ACCW  = 5'd19;
  localparam logic [OP_W-1:0] OP_RND0  = 5'd20;
  localparam logic [OP_W-1:0] OP_RND1  = 5'd21;
  localparam logic [OP_W-1:0] OP_FIN   = 5'd22;
  localparam logic [OP_W-1:0] OP_PUSH  = 5'd23;

  localparam logic FACE_LEFT  = 1'b0;
  localparam logic FACE_RIGHT = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          line_start;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_face;
    logic signed [SAMPLE_BITS-1:0] right_face;
  } out_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      idx;
    logic            face;
  } dp_cmd_t;

  typedef struct packed {
    logic full_now;
    logic mx_big;
    logic c_big;
    logic div_done;
    logic out_free;
  } dp_sts_t;

  // linear weight times inverse square: 1:6:3 on the left face, 3:6:1 on the right
  function automatic logic [C_W-1:0] gscale(input logic face, input logic [1:0] idx,
                                            input logic [DVD_W-1:0] quot);
    logic [C_W-1:0] q;
    logic [C_W-1:0] r;
    q = C_W'(quot);
    case (idx)
      2'd0:    r = (face == FACE_RIGHT) ? (q << 1) + q : q;
      2'd1:    r = (q << 2) + (q << 1);
      2'd2:    r = (face == FACE_RIGHT) ? q : (q << 1) + q;
      default: r = q;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/weno5_interface_reconstruction.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// weno5_interface_reconstruction
// Fifth-order WENO reconstruction of both cell faces from a sample stream.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one Q4.20 sample and a
// line_start flag per transaction. Output channel out_valid/out_stall/
// out_data carries the left (i+1/2) and right (i-1/2) face values of the
// window centre, saturated to Q4.20.
// The first four samples of a line only fill the window and give no
// result. Every later sample gives one result. The work on each is made
// up of nine divisions on the one shared restoring divider (three inverse
// squares, then three weights per face), plus normalising shifts for the
// indicators and, per face, for the weights.
// One sample is worked on at a time; in_stall is low only while the
// sequencer is idle. A finished result waits in the output register while
// the next sample is taken; if it is still stalled when the following
// result is ready, the sequencer holds until it is taken.
// Reset clears the window count, the sequencer and the output valid.
// ---------------------------------------------------------------------------
module weno5_interface_reconstruction
  import weno5_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  weno5_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  weno5_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* rtl/core/weno5_div.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// weno5_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module weno5_div
  import weno5_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;

  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;
  logic [DVS_W-1:0]  rem_nxt;

  assign trial   = {rem_r, quo_r[DVD_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign ge      = (trial >= {1'b0, dvs_r});
  assign rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

/* rtl/core/weno5_dp.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// weno5_dp
// Datapath: sample window, shared multiplier, divider and result register.
// ---------------------------------------------------------------------------
module weno5_dp
  import weno5_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire dp_cmd_t cmd,
  input  wire in_t     in_data,
  input  wire logic    out_stall,
  output dp_sts_t      sts,
  output logic         out_valid,
  output out_t         out_data
);

  logic signed [SAMPLE_BITS-1:0] win_r [4];
  logic [FILL_W-1:0]             fill_r;
  logic signed [SAMPLE_BITS-1:0] v_r [5];
  logic [D_W-1:0]                d_r [3];
  logic [D_W-1:0]                mx_r;
  logic [DVD_W-1:0]              quot_r [3];
  logic [C_W-1:0]                c_r [3];
  logic [CS_W-1:0]               csum_r;
  logic [CS2_W-1:0]              cs2_r;
  logic [W_W-1:0]                w_r [3];
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic [Z_W-1:0]                z_r;
  logic signed [SAMPLE_BITS-1:0] res_l_r;
  logic signed [SAMPLE_BITS-1:0] res_r_r;
  logic                          out_valid_r;
  out_t                          out_data_r;

  logic signed [DIFF_W-1:0] e  [5];
  logic signed [DIFF_W-1:0] a  [3];
  logic signed [DIFF_W-1:0] b  [3];
  logic signed [DIFF_W-1:0] am [3];
  logic signed [DIFF_W-1:0] bm [3];
  logic signed [Q_W-1:0]    qe [5];
  logic signed [Q_W-1:0]    ql [3];
  logic signed [Q_W-1:0]    qr [3];
  logic signed [Q_W-1:0]    qsel;
  logic [DN_BITS-1:0]       dq;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [D_W-1:0]           p_d;
  logic [C_W-1:0]           c_init [3];
  logic [CS_W-1:0]          c_sum;
  logic [CS2_W-1:0]         cs2_sum;
  logic signed [ACC_W-1:0]  rsum;
  logic signed [ACC_W-1:0]  ysh;
  logic signed [ACC_W-1:0]  zsum;
  logic signed [R_W-1:0]    rdiv;
  logic signed [R_W-1:0]    rsat;
  logic                     mx_big;
  logic                     c_big;
  logic                     push;
  logic                     out_free;
  logic                     div_start;
  logic [DVD_W-1:0]         div_dvd;
  logic [DVS_W-1:0]         div_dvs;
  logic                     div_done;
  logic [DVD_W-1:0]         div_q;

  // smoothness differences and stencil numerators
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      e[i]  = DIFF_W'(v_r[i]);
      qe[i] = Q_W'(v_r[i]);
    end
    a[0] = e[0] - (e[1] <<< 1) + e[2];
    b[0] = e[0] - (e[1] <<< 2) + (e[2] <<< 1) + e[2];
    a[1] = e[1] - (e[2] <<< 1) + e[3];
    b[1] = e[1] - e[3];
    a[2] = e[2] - (e[3] <<< 1) + e[4];
    b[2] = (e[2] <<< 1) + e[2] - (e[3] <<< 2) + e[4];
    for (int i = 0; i < 3; i++) begin
      am[i] = a[i][DIFF_W-1] ? -a[i] : a[i];
      bm[i] = b[i][DIFF_W-1] ? -b[i] : b[i];
    end
    ql[0] = (qe[0] <<< 1) - ((qe[1] <<< 3) - qe[1]) + (qe[2] <<< 3) + (qe[2] <<< 1) + qe[2];
    ql[1] = (qe[2] <<< 2) + qe[2] + (qe[3] <<< 1) - qe[1];
    ql[2] = (qe[2] <<< 1) + (qe[3] <<< 2) + qe[3] - qe[4];
    qr[0] = (qe[1] <<< 2) + qe[1] + (qe[2] <<< 1) - qe[0];
    qr[1] = (qe[1] <<< 1) + (qe[2] <<< 2) + qe[2] - qe[3];
    qr[2] = (qe[2] <<< 3) + (qe[2] <<< 1) + qe[2] - ((qe[3] <<< 3) - qe[3]) + (qe[4] <<< 1);
  end

  assign qsel = (cmd.face == FACE_RIGHT) ? qr[cmd.idx] : ql[cmd.idx];
  assign dq   = (d_r[cmd.idx][DN_BITS-1:0] == '0) ? DN_BITS'(1) : d_r[cmd.idx][DN_BITS-1:0];

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQA: begin
        mul_a = MUL_W'(am[cmd.idx]);
        mul_b = MUL_W'(am[cmd.idx]);
      end
      OP_SQB: begin
        mul_a = MUL_W'(bm[cmd.idx]);
        mul_b = MUL_W'(bm[cmd.idx]);
      end
      OP_SQD: begin
        mul_a = {{(MUL_W-DN_BITS){1'b0}}, dq};
        mul_b = {{(MUL_W-DN_BITS){1'b0}}, dq};
      end
      OP_MW: begin
        mul_a = {{(MUL_W-W_W){1'b0}}, w_r[cmd.idx]};
        mul_b = MUL_W'(qsel);
      end
      OP_RND1: begin
        mul_a = {{(MUL_W-Z_W){1'b0}}, z_r};
        mul_b = RECIP3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign p_d      = prod_r[D_W-1:0];
  assign mx_big   = |mx_r[D_W-1:DN_BITS];
  assign c_big    = |csum_r[CS_W-1:CN_BITS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_init[i] = gscale(cmd.face, 2'(i), quot_r[i]);
    end
    c_sum   = CS_W'(c_init[0]) + CS_W'(c_init[1]) + CS_W'(c_init[2]);
    cs2_sum = CS2_W'(c_r[0][CN_BITS-1:0]) + CS2_W'(c_r[1][CN_BITS-1:0])
            + CS2_W'(c_r[2][CN_BITS-1:0]);
  end

  // floor((A + 3*2^24) / 2^25), offset positive for the divide by three
  assign rsum = acc_r + RND_OFF;
  assign ysh  = rsum >>> RND_SH;
  assign zsum = ysh + Z_OFF;
  assign rdiv = $signed({1'b0, prod_r[RECIP_SH+Z_W-1:RECIP_SH]}) - Q_OFF;
  assign rsat = (rdiv > RES_MAX) ? RES_MAX : ((rdiv < RES_MIN) ? RES_MIN : rdiv);

  assign div_start = (cmd.op == OP_DIVQ) || (cmd.op == OP_DIVW);
  assign div_dvd   = (cmd.op == OP_DIVQ) ? INV_NUM
                   : {{(DVD_W-CN_BITS-WEIGHT_BITS){1'b0}},
                      c_r[cmd.idx][CN_BITS-1:0], {WEIGHT_BITS{1'b0}}};
  assign div_dvs   = (cmd.op == OP_DIVQ) ? prod_r[DVS_W-1:0] : DVS_W'(cs2_r);

  weno5_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign push     = (cmd.op == OP_PUSH) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_LOAD) begin
        if (in_data.line_start) begin
          fill_r <= FILL_W'(1);
        end else if (fill_r != FILL_FULL) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < 4; i++) v_r[i] <= win_r[i];
        v_r[4] <= in_data.sample;
        for (int i = 0; i < 3; i++) win_r[i] <= win_r[i+1];
        win_r[3] <= in_data.sample;
      end
      OP_DINIT: begin
        for (int i = 0; i < 3; i++) d_r[i] <= EPS_VAL;
      end
      OP_SQA, OP_SQB, OP_SQD, OP_MW, OP_RND1: begin
        prod_r <= prod_nxt;
      end
      OP_ACCA: begin
        d_r[cmd.idx] <= d_r[cmd.idx] + (p_d << 3) + (p_d << 2) + p_d;
      end
      OP_ACCB: begin
        d_r[cmd.idx] <= d_r[cmd.idx] + (p_d << 1) + p_d;
      end
      OP_MAXD: begin
        if ((d_r[0] >= d_r[1]) && (d_r[0] >= d_r[2])) begin
          mx_r <= d_r[0];
        end else if (d_r[1] >= d_r[2]) begin
          mx_r <= d_r[1];
        end else begin
          mx_r <= d_r[2];
        end
      end
      OP_NORM1: begin
        if (mx_big) begin
          mx_r <= mx_r >> 1;
          for (int i = 0; i < 3; i++) d_r[i] <= d_r[i] >> 1;
        end
      end
      OP_STQ: begin
        quot_r[cmd.idx] <= div_q;
      end
      OP_CINIT: begin
        for (int i = 0; i < 3; i++) c_r[i] <= c_init[i];
        csum_r <= c_sum;
      end
      OP_NORM2: begin
        if (c_big) begin
          csum_r <= csum_r >> 1;
          for (int i = 0; i < 3; i++) c_r[i] <= c_r[i] >> 1;
        end
      end
      OP_CSUM: begin
        cs2_r <= (cs2_sum == '0) ? CS2_W'(1) : cs2_sum;
      end
      OP_STW: begin
        w_r[cmd.idx] <= div_q[W_W-1:0];
      end
      OP_ACLR: begin
        acc_r <= '0;
      end
      OP_ACCW: begin
        acc_r <= acc_r + prod_r[ACC_W-1:0];
      end
      OP_RND0: begin
        z_r <= zsum[Z_W-1:0];
      end
      OP_FIN: begin
        if (cmd.face == FACE_RIGHT) begin
          res_r_r <= rsat[SAMPLE_BITS-1:0];
        end else begin
          res_l_r <= rsat[SAMPLE_BITS-1:0];
        end
      end
      OP_PUSH: begin
        if (out_free) begin
          out_data_r.left_face  <= res_l_r;
          out_data_r.right_face <= res_r_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.full_now = !in_data.line_start && (fill_r == FILL_FULL);
  assign sts.mx_big   = mx_big;
  assign sts.c_big    = c_big;
  assign sts.div_done = div_done;
  assign sts.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* rtl/core/weno5_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// weno5_ctrl
// Sequencer: steps the datapath through indicators, weights and faces.
// ---------------------------------------------------------------------------
module weno5_ctrl
  import weno5_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire dp_sts_t sts,
  output logic         in_stall,
  output dp_cmd_t      cmd
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] ST_DINIT = 5'd1;
  localparam logic [ST_W-1:0] ST_SQA   = 5'd2;
  localparam logic [ST_W-1:0] ST_ACCA  = 5'd3;
  localparam logic [ST_W-1:0] ST_SQB   = 5'd4;
  localparam logic [ST_W-1:0] ST_ACCB  = 5'd5;
  localparam logic [ST_W-1:0] ST_MAXD  = 5'd6;
  localparam logic [ST_W-1:0] ST_NORM1 = 5'd7;
  localparam logic [ST_W-1:0] ST_SQD   = 5'd8;
  localparam logic [ST_W-1:0] ST_DIVQ  = 5'd9;
  localparam logic [ST_W-1:0] ST_WAITQ = 5'd10;
  localparam logic [ST_W-1:0] ST_CINIT = 5'd11;
  localparam logic [ST_W-1:0] ST_NORM2 = 5'd12;
  localparam logic [ST_W-1:0] ST_CSUM  = 5'd13;
  localparam logic [ST_W-1:0] ST_DIVW  = 5'd14;
  localparam logic [ST_W-1:0] ST_WAITW = 5'd15;
  localparam logic [ST_W-1:0] ST_ACLR  = 5'd16;
  localparam logic [ST_W-1:0] ST_MW    = 5'd17;
  localparam logic [ST_W-1:0] ST_ACCW  = 5'd18;
  localparam logic [ST_W-1:0] ST_RND0  = 5'd19;
  localparam logic [ST_W-1:0] ST_RND1  = 5'd20;
  localparam logic [ST_W-1:0] ST_FIN   = 5'd21;
  localparam logic [ST_W-1:0] ST_OUT   = 5'd22;

  localparam logic [1:0] IDX_LAST = 2'd2;

  logic [ST_W-1:0] state_r, state_nxt;
  logic [1:0]      k_r, k_nxt;
  logic            f_r, f_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    f_nxt     = f_r;
    cmd.op    = OP_NOP;
    cmd.idx   = k_r;
    cmd.face  = f_r;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (sts.full_now) state_nxt = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd.op    = OP_DINIT;
        k_nxt     = 2'd0;
        state_nxt = ST_SQA;
      end
      ST_SQA: begin
        cmd.op    = OP_SQA;
        state_nxt = ST_ACCA;
      end
      ST_ACCA: begin
        cmd.op    = OP_ACCA;
        state_nxt = ST_SQB;
      end
      ST_SQB: begin
        cmd.op    = OP_SQB;
        state_nxt = ST_ACCB;
      end
      ST_ACCB: begin
        cmd.op = OP_ACCB;
        if (k_r == IDX_LAST) begin
          k_nxt     = 2'd0;
          state_nxt = ST_MAXD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_SQA;
        end
      end
      ST_MAXD: begin
        cmd.op    = OP_MAXD;
        state_nxt = ST_NORM1;
      end
      ST_NORM1: begin
        // halve all indicators until the largest fits the normalised width
        cmd.op = OP_NORM1;
        if (!sts.mx_big) state_nxt = ST_SQD;
      end
      ST_SQD: begin
        cmd.op    = OP_SQD;
        state_nxt = ST_DIVQ;
      end
      ST_DIVQ: begin
        cmd.op    = OP_DIVQ;
        state_nxt = ST_WAITQ;
      end
      ST_WAITQ: begin
        if (sts.div_done) begin
          cmd.op = OP_STQ;
          if (k_r == IDX_LAST) begin
            k_nxt     = 2'd0;
            f_nxt     = FACE_LEFT;
            state_nxt = ST_CINIT;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_SQD;
          end
        end
      end
      ST_CINIT: begin
        cmd.op    = OP_CINIT;
        state_nxt = ST_NORM2;
      end
      ST_NORM2: begin
        cmd.op = OP_NORM2;
        if (!sts.c_big) state_nxt = ST_CSUM;
      end
      ST_CSUM: begin
        cmd.op    = OP_CSUM;
        k_nxt     = 2'd0;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        cmd.op    = OP_DIVW;
        state_nxt = ST_WAITW;
      end
      ST_WAITW: begin
        if (sts.div_done) begin
          cmd.op = OP_STW;
          if (k_r == IDX_LAST) begin
            k_nxt     = 2'd0;
            state_nxt = ST_ACLR;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_DIVW;
          end
        end
      end
      ST_ACLR: begin
        cmd.op    = OP_ACLR;
        state_nxt = ST_MW;
      end
      ST_MW: begin
        cmd.op    = OP_MW;
        state_nxt = ST_ACCW;
      end
      ST_ACCW: begin
        cmd.op = OP_ACCW;
        if (k_r == IDX_LAST) begin
          k_nxt     = 2'd0;
          state_nxt = ST_RND0;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_MW;
        end
      end
      ST_RND0: begin
        cmd.op    = OP_RND0;
        state_nxt = ST_RND1;
      end
      ST_RND1: begin
        cmd.op    = OP_RND1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.op = OP_FIN;
        if (f_r == FACE_LEFT) begin
          f_nxt     = FACE_RIGHT;
          state_nxt = ST_CINIT;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the result register is free
        cmd.op = OP_PUSH;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= 2'd0;
      f_r     <= FACE_LEFT;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      f_r     <= f_nxt;
    end
  end

endmodule
`default_nettype wire

/* tb/weno5_interface_reconstruction_tb.sv */
// ---------------------------------------------------------------------------
// weno5_interface_reconstruction_tb
// Drives a sample stream into the WENO5 face reconstruction block and
// compares every output transaction with an integer predictor of the window.
// ---------------------------------------------------------------------------
module weno5_interface_reconstruction_tb
  import weno5_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 800;

  class face_scoreboard;
    longint win[4];
    int     held;
    out_t   pending[$];
    int     errors;

    function new();
      foreach (win[k]) win[k] = 0;
      held = 0;
      errors = 0;
    endfunction

    static function int bitlen(logic [63:0] x);
      int n;
      n = 0;
      while (x != 0) begin
        n++;
        x = x >> 1;
      end
      return n;
    endfunction

    static function logic [63:0] smooth(longint a, longint b);
      logic [63:0] ua, ub;
      if (a > (64'sd1 <<< 29)) a = 64'sd1 <<< 29;
      if (a < -(64'sd1 <<< 29)) a = -(64'sd1 <<< 29);
      if (b > (64'sd1 <<< 29)) b = 64'sd1 <<< 29;
      if (b < -(64'sd1 <<< 29)) b = -(64'sd1 <<< 29);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      return 13 * ua * ua + 3 * ub * ub;
    endfunction

    static function logic signed [SAMPLE_BITS-1:0] blend(logic [63:0] d[3], int g[3],
                                                         longint q[3]);
      logic [63:0] mx, dp, c[3], csum, csum2;
      int sh, sh2;
      longint acc, den, r, w, lim;
      mx = d[0];
      if (d[1] > mx) mx = d[1];
      if (d[2] > mx) mx = d[2];
      sh = bitlen(mx) - 21;
      if (sh < 0) sh = 0;
      csum = 0;
      for (int k = 0; k < 3; k++) begin
        dp = d[k] >> sh;
        if (dp == 0) dp = 1;
        c[k] = g[k] * ((64'd1 << 59) / (dp * dp));
        csum += c[k];
      end
      sh2 = bitlen(csum) - 32;
      if (sh2 < 0) sh2 = 0;
      csum2 = 0;
      for (int k = 0; k < 3; k++) begin
        c[k] = c[k] >> sh2;
        csum2 += c[k];
      end
      if (csum2 == 0) csum2 = 1;
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        w = longint'((c[k] << WEIGHT_BITS) / csum2);
        acc += w * q[k];
      end
      den = 64'sd6 <<< WEIGHT_BITS;
      acc = acc + den / 2;
      if (acc >= 0) r = acc / den;
      else r = -((-acc + den - 1) / den);
      lim = 64'sd1 <<< (SAMPLE_BITS - 1);
      if (r > lim - 1) r = lim - 1;
      if (r < -lim) r = -lim;
      return r[SAMPLE_BITS-1:0];
    endfunction

    // advance the window and queue the two face values when it is full
    function void note_sample(in_t s);
      longint v1, v2, v3, v4, v5;
      logic [63:0] d[3], e;
      longint q[3];
      int gl[3], gr[3];
      out_t o;
      gl = '{1, 6, 3};
      gr = '{3, 6, 1};
      v5 = longint'(s.sample);
      if (s.line_start) held = 0;
      if (held >= 4) begin
        v1 = win[0]; v2 = win[1]; v3 = win[2]; v4 = win[3];
        e = (64'd12 * (64'd1 << (2 * FRACTION_BITS)) + 64'd500000) / 64'd1000000;
        d[0] = smooth(v1 - 2 * v2 + v3, v1 - 4 * v2 + 3 * v3) + e;
        d[1] = smooth(v2 - 2 * v3 + v4, v2 - v4) + e;
        d[2] = smooth(v3 - 2 * v4 + v5, 3 * v3 - 4 * v4 + v5) + e;
        q[0] = 2 * v1 - 7 * v2 + 11 * v3;
        q[1] = -v2 + 5 * v3 + 2 * v4;
        q[2] = 2 * v3 + 5 * v4 - v5;
        o.left_face = blend(d, gl, q);
        q[0] = -v1 + 5 * v2 + 2 * v3;
        q[1] = 2 * v2 + 5 * v3 - v4;
        q[2] = 11 * v3 - 7 * v4 + 2 * v5;
        o.right_face = blend(d, gr, q);
        pending.push_back(o);
      end
      for (int k = 0; k < 3; k++) win[k] = win[k + 1];
      win[3] = v5;
      if (held < 4) held++;
    endfunction

    function void check_faces(out_t got);
      out_t exp_o;
      if (pending.size() == 0) begin
        $error("unexpected result left_face=%0d right_face=%0d",
               got.left_face, got.right_face);
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      if (got.left_face !== exp_o.left_face) begin
        $error("left_face expected %0d actual %0d", exp_o.left_face, got.left_face);
        errors++;
      end
      if (got.right_face !== exp_o.right_face) begin
        $error("right_face expected %0d actual %0d", exp_o.right_face, got.right_face);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  face_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  bit stim_done = 1'b0;

  always #1 clk = ~clk;

  weno5_interface_reconstruction DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_sample(in_data);
      if (out_valid && !out_stall) sb.check_faces(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stall, changed at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, logic ls);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.sample <= s;
    in_data.line_start <= ls;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample(int style, int base);
    case (style)
      0: return SAMPLE_BITS'($urandom);
      1: return SAMPLE_BITS'(base + $signed($urandom_range(2000)) - 1000);
      2: return ($urandom_range(1)) ? 24'sh7FFFFF : -24'sh800000;
      default: return SAMPLE_BITS'(base + $signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic run_random(int n);
    int base, style, run;
    for (int i = 0; i < n; ) begin
      // mostly lines of several samples, now and then a stray restart
      run = $urandom_range(4, 16);
      style = $urandom_range(3);
      base = $signed($urandom) >>> 9;
      for (int j = 0; j < run && i < n; j++, i++) begin
        send_sample(rand_sample(style, base), (j == 0) || ($urandom_range(49) == 0));
        base = base + $signed($urandom_range(4000)) - 2000;
      end
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 58;

    // directed: flat, extremes, steps, alternating, restarts mid-fill
    send_sample('0, 1'b1);
    repeat (5) send_sample('0, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh800000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh800000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh7FFFFF, 1'b1);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh100000, 1'b1);
    send_sample(24'sh100000, 1'b0);
    send_sample(24'sh100000, 1'b0);
    send_sample(24'sh100000, 1'b0);
    send_sample(24'sh100000, 1'b0);
    send_sample(-24'sh100000, 1'b0);
    send_sample(-24'sh100000, 1'b0);
    send_sample(24'sh000001, 1'b0);
    send_sample(-24'sh000001, 1'b0);
    send_sample(24'sh555555, 1'b0);
    send_sample(-24'sh2AAAAB, 1'b0);

    run_random(140);
    send_idle_pct = 58;
    recv_idle_pct = 27;
    run_random(140);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(140);
    in_valid <= 1'b0;

    stim_done = 1'b1;
    wait_cycles = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    while (wait_cycles < TAIL_CYCLES) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
